>>> hdl/clft_pkg.sv
// ----------------------------------------------------------------------------
// clft_pkg
// Shared widths, codes and defaults of the collision layer filter table.
// ----------------------------------------------------------------------------
package clft_pkg;

  localparam int unsigned ID_W         = 32;
  localparam int unsigned FIELD_W      = 32;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 32;
  localparam int unsigned ENTRIES_DEF  = 64;
  localparam int unsigned MASK_BITS_DEF = 32;

  localparam logic [FIELD_W-1:0] DEFAULT_LAYER_RST = 32'h0000_0001;
  localparam logic [FIELD_W-1:0] DEFAULT_MASK_RST  = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    CMD_REGISTER   = 2'd0,
    CMD_UNREGISTER = 2'd1,
    CMD_CLASSIFY   = 2'd2,
    CMD_QUERY      = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    EVT_NONE    = 2'd0,
    EVT_CONTACT = 2'd1,
    EVT_TRIGGER = 2'd2
  } event_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEFAULT_LAYER = 2'd0,
    CFG_DEFAULT_MASK  = 2'd1,
    CFG_TRIGGER_SINK  = 2'd2,
    CFG_CONTACT_SINK  = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_FIN   = 4'b1000
  } state_e;

endpackage

>>> hdl/clft_if.sv
// ----------------------------------------------------------------------------
// clft_in_if / clft_out_if
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
interface clft_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  command;
  logic [clft_pkg::ID_W-1:0]   body_a;
  logic [clft_pkg::ID_W-1:0]   body_b;
  logic [clft_pkg::FIELD_W-1:0] layer_in;
  logic [clft_pkg::FIELD_W-1:0] mask_in;
  logic                        trigger_in;

  modport source (output valid, command, body_a, body_b, layer_in, mask_in, trigger_in,
                  input ready);
  modport sink   (input valid, command, body_a, body_b, layer_in, mask_in, trigger_in,
                  output ready);
endinterface

interface clft_out_if;
  logic                         valid;
  logic                         ready;
  logic                         status;
  logic [1:0]                   event_kind;
  logic [clft_pkg::ID_W-1:0]    pair_first;
  logic [clft_pkg::ID_W-1:0]    pair_second;
  logic                         is_trigger_pair;
  logic                         found;
  logic [clft_pkg::FIELD_W-1:0] layer_out;
  logic [clft_pkg::FIELD_W-1:0] mask_out;

  modport source (output valid, status, event_kind, pair_first, pair_second,
                  is_trigger_pair, found, layer_out, mask_out, input ready);
  modport sink   (input valid, status, event_kind, pair_first, pair_second,
                  is_trigger_pair, found, layer_out, mask_out, output ready);
endinterface

>>> hdl/clft_ram.sv
// ----------------------------------------------------------------------------
// clft_ram
// Slot store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module clft_ram #(
  parameter int unsigned DEPTH = clft_pkg::ENTRIES_DEF,
  parameter int unsigned WIDTH = 97,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/collision_layer_filter_table_top.sv
// ----------------------------------------------------------------------------
// collision_layer_filter_table_top
// Body table with layer/mask filtering of contact pairs.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  in_i     in   valid/ready        command, body_a, body_b, layer_in, mask_in, trigger_in
//  out_o    out  valid/ready        status, event_kind, pair_first/second, found, ...
//  cfg      in   cfg_we_i           cfg_idx_i, cfg_data_i
//
//  during a command one slot per cycle is read from the single read port of the
//  slot memory, both ids compared at once
//  valid bits are flops cleared by reset; no clearing pass is needed
//  one word is worked at a time; a finished result waits in the output register,
//  and a new word is taken as soon as that result is loaded
// ----------------------------------------------------------------------------
module collision_layer_filter_table_top #(
  parameter int unsigned ENTRIES   = clft_pkg::ENTRIES_DEF,
  parameter int unsigned MASK_BITS = clft_pkg::MASK_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  clft_in_if.sink                             in_i,
  clft_out_if.source                          out_o,
  input  logic                                cfg_we_i,
  input  logic [clft_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [clft_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned AW   = $clog2(ENTRIES);
  localparam int unsigned IW   = clft_pkg::ID_W;
  localparam int unsigned FW   = clft_pkg::FIELD_W;
  localparam int unsigned DW   = IW + 2 * MASK_BITS + 1;
  localparam int unsigned L_LO = IW;
  localparam int unsigned M_LO = IW + MASK_BITS;
  localparam int unsigned T_B  = IW + 2 * MASK_BITS;
  localparam logic [AW-1:0] LAST_IDX = AW'(ENTRIES - 1);

  // configuration
  logic [FW-1:0] def_layer_q, def_mask_q;
  logic          trig_sink_q, cont_sink_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      def_layer_q <= clft_pkg::DEFAULT_LAYER_RST;
      def_mask_q  <= clft_pkg::DEFAULT_MASK_RST;
      trig_sink_q <= 1'b0;
      cont_sink_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (clft_pkg::cfg_idx_e'(cfg_idx_i))
        clft_pkg::CFG_DEFAULT_LAYER: def_layer_q <= FW'(cfg_data_i);
        clft_pkg::CFG_DEFAULT_MASK:  def_mask_q  <= FW'(cfg_data_i);
        clft_pkg::CFG_TRIGGER_SINK:  trig_sink_q <= cfg_data_i[0];
        clft_pkg::CFG_CONTACT_SINK:  cont_sink_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // control
  clft_pkg::state_e state_q, state_d;
  logic [AW-1:0]    idx_q;
  logic             cmp_vld_q;
  logic [AW-1:0]    cmp_idx_q;
  logic             out_vld_q;
  logic             in_acc, out_load, scan_rd;

  assign in_i.ready = (state_q == clft_pkg::ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_load   = (state_q == clft_pkg::ST_FIN) && (!out_vld_q || out_o.ready);
  assign scan_rd    = (state_q == clft_pkg::ST_SCAN);

  always_comb begin
    state_d = state_q;
    case (state_q)
      clft_pkg::ST_IDLE:  if (in_acc) state_d = clft_pkg::ST_SCAN;
      clft_pkg::ST_SCAN:  if (idx_q == LAST_IDX) state_d = clft_pkg::ST_DRAIN;
      clft_pkg::ST_DRAIN: state_d = clft_pkg::ST_FIN;
      clft_pkg::ST_FIN:   if (out_load) state_d = clft_pkg::ST_IDLE;
      default:            state_d = clft_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= clft_pkg::ST_IDLE;
      idx_q     <= '0;
      cmp_vld_q <= 1'b0;
      cmp_idx_q <= '0;
    end else begin
      state_q   <= state_d;
      cmp_vld_q <= scan_rd;
      if (scan_rd) begin
        cmp_idx_q <= idx_q;
        idx_q     <= idx_q + AW'(1);
      end else begin
        idx_q <= '0;
      end
    end
  end

  // captured command word
  clft_pkg::cmd_e       cmd_q;
  logic [IW-1:0]        body_a_q, body_b_q;
  logic [MASK_BITS-1:0] layer_in_q, mask_in_q;
  logic                 trig_in_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q      <= clft_pkg::cmd_e'(in_i.command);
      body_a_q   <= in_i.body_a;
      body_b_q   <= in_i.body_b;
      layer_in_q <= MASK_BITS'(in_i.layer_in);
      mask_in_q  <= MASK_BITS'(in_i.mask_in);
      trig_in_q  <= in_i.trigger_in;
    end
  end

  // slot memory and valid bits
  logic [DW-1:0]      rdata, wdata;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [ENTRIES-1:0] valid_q;

  clft_ram #(
    .DEPTH (ENTRIES),
    .WIDTH (DW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wdata),
    .re_i    (scan_rd),
    .raddr_i (idx_q),
    .rdata_o (rdata)
  );

  logic match_a, match_b, cmp_slot_vld;
  assign cmp_slot_vld = cmp_vld_q && valid_q[cmp_idx_q];
  assign match_a      = cmp_slot_vld && (rdata[IW-1:0] == body_a_q);
  assign match_b      = cmp_slot_vld && (rdata[IW-1:0] == body_b_q);

  // search results, lowest slot wins
  logic                 hit_a_q, hit_b_q, free_q;
  logic [AW-1:0]        hit_idx_q, free_idx_q;
  logic [MASK_BITS-1:0] lay_a_q, msk_a_q, lay_b_q, msk_b_q;
  logic                 trg_a_q, trg_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_a_q <= 1'b0;
      hit_b_q <= 1'b0;
      free_q  <= 1'b0;
    end else if (in_acc) begin
      hit_a_q <= 1'b0;
      hit_b_q <= 1'b0;
      free_q  <= 1'b0;
    end else begin
      if (match_a && !hit_a_q) hit_a_q <= 1'b1;
      if (match_b && !hit_b_q) hit_b_q <= 1'b1;
      if (cmp_vld_q && !valid_q[cmp_idx_q] && !free_q) free_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (match_a && !hit_a_q) begin
      hit_idx_q <= cmp_idx_q;
      lay_a_q   <= rdata[M_LO-1:L_LO];
      msk_a_q   <= rdata[T_B-1:M_LO];
      trg_a_q   <= rdata[T_B];
    end
    if (match_b && !hit_b_q) begin
      lay_b_q <= rdata[M_LO-1:L_LO];
      msk_b_q <= rdata[T_B-1:M_LO];
      trg_b_q <= rdata[T_B];
    end
    if (cmp_vld_q && !valid_q[cmp_idx_q] && !free_q) begin
      free_idx_q <= cmp_idx_q;
    end
  end

  // finish: write back and build the result
  logic                 is_reg, reg_ok, unreg_clr;
  logic [MASK_BITS-1:0] la, ma, lb, mb;
  logic                 pass, trig;
  clft_pkg::event_e     kind;

  assign is_reg    = (cmd_q == clft_pkg::CMD_REGISTER);
  assign reg_ok    = hit_a_q || free_q;
  assign wr_en     = out_load && is_reg && reg_ok;
  assign wr_addr   = hit_a_q ? hit_idx_q : free_idx_q;
  assign wdata     = {trig_in_q, mask_in_q, layer_in_q, body_a_q};
  assign unreg_clr = match_a && (cmd_q == clft_pkg::CMD_UNREGISTER);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (wr_en) valid_q[wr_addr] <= 1'b1;
      if (unreg_clr) valid_q[cmp_idx_q] <= 1'b0;
    end
  end

  assign la   = hit_a_q ? lay_a_q : MASK_BITS'(def_layer_q);
  assign ma   = hit_a_q ? msk_a_q : MASK_BITS'(def_mask_q);
  assign lb   = hit_b_q ? lay_b_q : MASK_BITS'(def_layer_q);
  assign mb   = hit_b_q ? msk_b_q : MASK_BITS'(def_mask_q);
  assign pass = (|(la & mb)) && (|(lb & ma));
  assign trig = (hit_a_q && trg_a_q) || (hit_b_q && trg_b_q);

  always_comb begin
    kind = clft_pkg::EVT_NONE;
    if (pass) begin
      if (trig && trig_sink_q) kind = clft_pkg::EVT_TRIGGER;
      else if (cont_sink_q)    kind = clft_pkg::EVT_CONTACT;
    end
  end

  // output register
  logic          status_q, trig_pair_q, found_q;
  logic [1:0]    kind_q;
  logic [IW-1:0] first_q, second_q;
  logic [FW-1:0] lay_out_q, msk_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      status_q    <= 1'b0;
      kind_q      <= clft_pkg::EVT_NONE;
      first_q     <= '0;
      second_q    <= '0;
      trig_pair_q <= 1'b0;
      found_q     <= 1'b0;
      lay_out_q   <= '0;
      msk_out_q   <= '0;
      case (cmd_q)
        clft_pkg::CMD_REGISTER: status_q <= !reg_ok;
        clft_pkg::CMD_CLASSIFY: begin
          kind_q      <= kind;
          trig_pair_q <= trig;
          if (kind != clft_pkg::EVT_NONE) begin
            first_q  <= body_a_q;
            second_q <= body_b_q;
          end
        end
        clft_pkg::CMD_QUERY: begin
          found_q   <= hit_a_q;
          lay_out_q <= FW'(la);
          msk_out_q <= FW'(ma);
        end
        default: ;
      endcase
    end
  end

  assign out_o.valid           = out_vld_q;
  assign out_o.status          = status_q;
  assign out_o.event_kind      = kind_q;
  assign out_o.pair_first      = first_q;
  assign out_o.pair_second     = second_q;
  assign out_o.is_trigger_pair = trig_pair_q;
  assign out_o.found           = found_q;
  assign out_o.layer_out       = lay_out_q;
  assign out_o.mask_out        = msk_out_q;

`ifndef SYNTHESIS
  // a refused register means every slot was taken
  a_full_refusal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && is_reg && !reg_ok) |-> (&valid_q))
    else $error("register refused with a free slot");

  // the chosen free slot really is free
  a_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && !hit_a_q) |-> !valid_q[free_idx_q])
    else $error("register overwrote a valid slot");

  // an update in place hits a live slot
  a_hit_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && hit_a_q) |-> valid_q[hit_idx_q])
    else $error("update targets an invalid slot");

  // the compare stage only runs in the cycle after a scan read
  a_cmp_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_vld_q |-> ($past(state_q) == clft_pkg::ST_SCAN))
    else $error("compare without a read");
`endif

endmodule
